// ----- design/txlift_pkg.sv -----
package txlift_pkg;

    localparam int MAX_EXONS_DEF  = 64;
    localparam int COORD_BITS_DEF = 32;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 6;
    localparam int FIELD_W = 32;
    localparam int CODE_W  = 3;
    localparam int CNT_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_EDIT  = 2'd2
    } op_t;

    typedef enum logic [CODE_W-1:0] {
        EC_M  = 3'd0,
        EC_EQ = 3'd1,
        EC_X  = 3'd2,
        EC_I  = 3'd3,
        EC_D  = 3'd4,
        EC_S  = 3'd5,
        EC_H  = 3'd6,
        EC_N  = 3'd7
    } edit_t;

    typedef enum logic [0:0] {
        REG_STRAND     = 1'b0,
        REG_EXON_COUNT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [CODE_W-1:0]  out_code;
        logic [FIELD_W-1:0] run_length;
        logic [FIELD_W-1:0] genome_start;
        logic [FIELD_W-1:0] genome_end;
        logic               strand_flip;
        logic               status;
        logic               run_last;
    } res_t;

endpackage

// ----- design/txlift_in_if.sv -----
interface txlift_in_if;
    logic                               valid;
    logic                               ready;
    logic [txlift_pkg::OP_W-1:0]        op;
    logic [txlift_pkg::SLOT_W-1:0]      exon_slot;
    logic [txlift_pkg::FIELD_W-1:0]     exon_first;
    logic [txlift_pkg::FIELD_W-1:0]     exon_final;
    logic [txlift_pkg::FIELD_W-1:0]     tx_start;
    logic [txlift_pkg::FIELD_W-1:0]     tx_end;
    logic [txlift_pkg::FIELD_W-1:0]     tx_length;
    logic [txlift_pkg::CODE_W-1:0]      edit_code;
    logic                               final_edit;

    modport source (
        output valid, op, exon_slot, exon_first, exon_final, tx_start, tx_end,
               tx_length, edit_code, final_edit,
        input  ready
    );

    modport sink (
        input  valid, op, exon_slot, exon_first, exon_final, tx_start, tx_end,
               tx_length, edit_code, final_edit,
        output ready
    );
endinterface

// ----- design/txlift_out_if.sv -----
interface txlift_out_if;
    logic                               valid;
    logic                               ready;
    logic [txlift_pkg::CODE_W-1:0]      out_code;
    logic [txlift_pkg::FIELD_W-1:0]     run_length;
    logic [txlift_pkg::FIELD_W-1:0]     genome_start;
    logic [txlift_pkg::FIELD_W-1:0]     genome_end;
    logic                               strand_flip;
    logic                               status;
    logic                               run_last;

    modport source (
        output valid, out_code, run_length, genome_start, genome_end,
               strand_flip, status, run_last,
        input  ready
    );

    modport sink (
        input  valid, out_code, run_length, genome_start, genome_end,
               strand_flip, status, run_last,
        output ready
    );
endinterface

// ----- design/transcript_to_genome_alignment_lift.sv -----
// Lifts a transcript alignment onto the genome through a table of exons.
// Channel "edits" carries three kinds of beat: an exon load (writes one table
// slot, no result), an alignment start (gives one result with the lifted
// genome start) and an alignment op (gives the op, plus an N beat for the
// intron when a match base ends an exon). Results leave on channel "lifted".
// The APB port holds strand_minus (0x0) and exon_count (0x4); write them only
// while the block is idle. The minus strand expects ops fed last to first.
// Flow: a load leaves the block idle for the next beat. An op goes to ST_EDIT,
// which puts its result in the output register and returns to idle. A start
// goes to ST_SRCH, which skips exons, one exon per cycle through the table's
// read port, then loads the lifted start and returns to idle. Both states wait
// to load while the output stage is busy. Table reads are registered: the
// current entry and the next entry's begin are held, with write forwarding.
// A result waits in a one-beat output register while the next beat is taken
// and worked on; a second entry holds the N beat. When the receiver stalls,
// the block finishes the item in hand and holds it until both entries free.
// Reset clears the control state and the valid flags, not the payload or read
// registers; the exon table keeps whatever it held and must be loaded before use.
module transcript_to_genome_alignment_lift #(
    parameter int MAX_EXONS  = txlift_pkg::MAX_EXONS_DEF,
    parameter int COORD_BITS = txlift_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [txlift_pkg::PADDR_W-1:0]   paddr,
    input  logic [txlift_pkg::PDATA_W-1:0]   pwdata,
    output logic [txlift_pkg::PDATA_W-1:0]   prdata,
    output logic                             pready,
    txlift_in_if.sink                        edits,
    txlift_out_if.source                     lifted
);

    localparam int CW    = COORD_BITS;
    localparam int AW    = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
    localparam int CNT_W = txlift_pkg::CNT_W;
    localparam int FW    = txlift_pkg::FIELD_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SRCH = 3'b010,
        ST_EDIT = 3'b100
    } state_t;

    function automatic logic [AW-1:0] slot_of(input logic [CNT_W:0] i);
        return (int'(i) < MAX_EXONS) ? AW'(i) : '0;
    endfunction

    // configuration
    logic               strand_reg;
    logic [CNT_W-1:0]   exon_count_reg;
    logic               cfg_wr;
    txlift_pkg::reg_idx_t cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign cfg_idx = txlift_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strand_reg     <= 1'b0;
            exon_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                txlift_pkg::REG_STRAND:     strand_reg     <= pwdata[0];
                txlift_pkg::REG_EXON_COUNT: exon_count_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            txlift_pkg::REG_STRAND:
                prdata = {{(txlift_pkg::PDATA_W-1){1'b0}}, strand_reg};
            txlift_pkg::REG_EXON_COUNT:
                prdata = {{(txlift_pkg::PDATA_W-CNT_W){1'b0}}, exon_count_reg};
            default:
                prdata = '0;
        endcase
    end

    // state
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cur_reg, cur_next;
    logic [CW-1:0]      consumed_reg, consumed_next;
    logic [CW-1:0]      ref_pos_reg, ref_pos_next;
    logic [CW-1:0]      lstart_reg, lstart_next;
    logic [CW-1:0]      lend_reg, lend_next;
    txlift_pkg::edit_t  code_reg, code_next;
    logic               last_reg, last_next;

    // exon table and read registers (entry cur and entry cur+1)
    logic [CW-1:0]      begin_mem [MAX_EXONS];
    logic [CW-1:0]      stop_mem  [MAX_EXONS];
    logic [CW-1:0]      beg_a_reg, stop_a_reg, beg_b_reg;
    logic               mem_we;
    logic [AW-1:0]      wa, ra_a, ra_b;
    logic [CW-1:0]      wbeg, wstop;

    // result path
    txlift_pkg::res_t   out_pay_reg, out_pay_next;
    txlift_pkg::res_t   pend_pay_reg, pend_pay_next;
    logic               out_valid_reg, out_valid_next;
    logic               pend_valid_reg, pend_valid_next;
    txlift_pkg::res_t   res0, res1;
    logic               res1_valid;
    logic               load_res;
    logic               can_load;

    // datapath terms
    logic               in_acc;
    logic [CNT_W-1:0]   live_n;
    logic [CNT_W:0]     cur_p1;
    logic               has_next;
    logic [CW-1:0]      len_cur;
    logic [CW:0]        lim;
    logic [CW-1:0]      lift_at;
    logic [CW:0]        pos_p1;
    logic               gap_ok;
    logic [CW:0]        intron_w;
    logic               is_base;
    logic               moves;
    logic               adv;
    logic               gap;
    logic               status;
    logic [CW-1:0]      lend_v;

    assign in_acc = edits.valid & edits.ready;
    assign edits.ready = (state_reg == ST_IDLE);

    assign live_n   = (int'(exon_count_reg) > MAX_EXONS) ? CNT_W'(MAX_EXONS)
                                                          : exon_count_reg;
    assign cur_p1   = {1'b0, cur_reg} + 1'b1;
    assign has_next = cur_p1 < {1'b0, live_n};
    assign len_cur  = stop_a_reg - beg_a_reg + CW'(1);
    assign lim      = {1'b0, consumed_reg} + {1'b0, len_cur};
    assign lift_at  = beg_a_reg - CW'(1) + ref_pos_reg - consumed_reg;
    assign pos_p1   = {1'b0, ref_pos_reg} + 1'b1;
    assign gap_ok   = {1'b0, beg_b_reg} > ({1'b0, stop_a_reg} + 1'b1);
    assign intron_w = {1'b0, beg_b_reg} - {1'b0, stop_a_reg} - 1'b1;
    assign status   = (live_n == '0);
    assign is_base  = (code_reg == txlift_pkg::EC_M) || (code_reg == txlift_pkg::EC_EQ)
                   || (code_reg == txlift_pkg::EC_X);
    assign moves    = !status && (is_base || code_reg == txlift_pkg::EC_D);
    assign adv      = moves && is_base && has_next && (pos_p1 >= lim);
    assign gap      = adv && gap_ok;
    assign lend_v   = moves ? lift_at : lend_reg;

    assign can_load = !pend_valid_reg && (!out_valid_reg || lifted.ready);

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        consumed_next = consumed_reg;
        ref_pos_next  = ref_pos_reg;
        lstart_next   = lstart_reg;
        lend_next     = lend_reg;
        code_next     = code_reg;
        last_next     = last_reg;
        mem_we        = 1'b0;
        load_res      = 1'b0;
        res1_valid    = 1'b0;
        res0          = '0;
        res1          = '0;
        res0.strand_flip = strand_reg;
        res1.strand_flip = strand_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (edits.op)
                        txlift_pkg::OP_LOAD:
                            mem_we = (int'(edits.exon_slot) < MAX_EXONS);
                        txlift_pkg::OP_START:
                        begin
                            ref_pos_next  = strand_reg
                                ? CW'(edits.tx_length) - CW'(edits.tx_end) - CW'(1)
                                : CW'(edits.tx_start);
                            cur_next      = '0;
                            consumed_next = '0;
                            state_next    = ST_SRCH;
                        end
                        txlift_pkg::OP_EDIT:
                        begin
                            code_next  = txlift_pkg::edit_t'(edits.edit_code);
                            last_next  = edits.final_edit;
                            state_next = ST_EDIT;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SRCH:
            begin
                res0.status = status;
                if (status)
                begin
                    if (can_load)
                    begin
                        lstart_next = '0;
                        lend_next   = '0;
                        load_res    = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
                else if (has_next && ({1'b0, ref_pos_reg} >= lim))
                begin
                    consumed_next = consumed_reg + len_cur;
                    cur_next      = cur_p1[CNT_W-1:0];
                end
                else if (can_load)
                begin
                    lstart_next       = lift_at;
                    lend_next         = lift_at;
                    res0.genome_start = FW'(lift_at);
                    res0.genome_end   = FW'(lift_at);
                    load_res          = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            ST_EDIT:
            begin
                if (can_load)
                begin
                    if (moves)
                    begin
                        ref_pos_next = pos_p1[CW-1:0];
                        lend_next    = lift_at;
                    end
                    if (adv)
                    begin
                        consumed_next = consumed_reg + len_cur;
                        cur_next      = cur_p1[CNT_W-1:0];
                    end
                    res0.out_code     = code_reg;
                    res0.run_length   = FW'(1);
                    res0.genome_start = FW'(lstart_reg);
                    res0.genome_end   = FW'(lend_v);
                    res0.status       = status;
                    res0.run_last     = gap ? 1'b0 : last_reg;
                    res1.out_code     = txlift_pkg::EC_N;
                    res1.run_length   = FW'(intron_w);
                    res1.genome_start = FW'(lstart_reg);
                    res1.genome_end   = FW'(lend_v);
                    res1.status       = status;
                    res1.run_last     = last_reg;
                    res1_valid        = gap;
                    load_res          = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    // table access: read addresses follow the next exon index
    assign wa    = AW'(edits.exon_slot);
    assign wbeg  = CW'(edits.exon_first);
    assign wstop = CW'(edits.exon_final);
    assign ra_a  = slot_of({1'b0, cur_next});
    assign ra_b  = slot_of({1'b0, cur_next} + 1'b1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            begin_mem[wa] <= wbeg;
            stop_mem[wa]  <= wstop;
        end
        beg_a_reg  <= (mem_we && wa == ra_a) ? wbeg  : begin_mem[ra_a];
        stop_a_reg <= (mem_we && wa == ra_a) ? wstop : stop_mem[ra_a];
        beg_b_reg  <= (mem_we && wa == ra_b) ? wbeg  : begin_mem[ra_b];
    end

    // output register and N-beat holding entry
    always_comb
    begin
        out_pay_next    = out_pay_reg;
        pend_pay_next   = pend_pay_reg;
        out_valid_next  = out_valid_reg;
        pend_valid_next = pend_valid_reg;
        priority if (pend_valid_reg && (!out_valid_reg || lifted.ready))
        begin
            out_pay_next    = pend_pay_reg;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (load_res)
        begin
            out_pay_next    = res0;
            out_valid_next  = 1'b1;
            pend_pay_next   = res1;
            pend_valid_next = res1_valid;
        end
        else if (lifted.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cur_reg        <= '0;
            consumed_reg   <= '0;
            ref_pos_reg    <= '0;
            lstart_reg     <= '0;
            lend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            consumed_reg   <= consumed_next;
            ref_pos_reg    <= ref_pos_next;
            lstart_reg     <= lstart_next;
            lend_reg       <= lend_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        last_reg     <= last_next;
        out_pay_reg  <= out_pay_next;
        pend_pay_reg <= pend_pay_next;
    end

    assign lifted.valid        = out_valid_reg;
    assign lifted.out_code     = out_pay_reg.out_code;
    assign lifted.run_length   = out_pay_reg.run_length;
    assign lifted.genome_start = out_pay_reg.genome_start;
    assign lifted.genome_end   = out_pay_reg.genome_end;
    assign lifted.strand_flip  = out_pay_reg.strand_flip;
    assign lifted.status       = out_pay_reg.status;
    assign lifted.run_last     = out_pay_reg.run_last;

    // N beat never waits without the op beat ahead of it
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("held N beat without an op beat in the output register");

    // a new result only goes into a free output stage
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_res |-> (!pend_valid_reg && (!out_valid_reg || lifted.ready)))
        else $error("result loaded over a beat still waiting");

    // the start search never moves the transcript position
    a_srch_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH) |=> $stable(ref_pos_reg))
        else $error("transcript position changed during the exon search");

    // an exon load produces no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && edits.op == txlift_pkg::OP_LOAD) |=> !load_res)
        else $error("exon load produced a result");

endmodule
